// ===== rtl/tcv_pkg.sv =====
// Shared types, constants and helpers of the container validator.
package tcv_pkg;

	localparam int unsigned HDR_BYTES     = 18;
	localparam int unsigned SEC_HDR_BYTES = 4;
	localparam int unsigned POS_VERSION   = 4;
	localparam int unsigned POS_DECLARED  = 6;
	localparam int unsigned POS_VENDOR    = 8;
	localparam int unsigned POS_TOTAL     = 14;
	localparam int unsigned FP_WORDS      = 3;

	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_EMPTY       = 3'd1;
	localparam logic [2:0] ST_BAD_MAGIC   = 3'd2;
	localparam logic [2:0] ST_BAD_VERSION = 3'd3;
	localparam logic [2:0] ST_BAD_LENGTH  = 3'd4;

	localparam logic CFG_MAGIC   = 1'b0;
	localparam logic CFG_VERSION = 1'b1;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       last_byte;
	} item_t;

	// Parse state as it stands after the word in flight has been taken.
	typedef struct packed {
		logic [31:0]           pos;
		logic [31:0]           magic;
		logic [15:0]           version;
		logic [15:0]           declared;
		logic [FP_WORDS-1:0][15:0] fp;
		logic [31:0]           total;
		logic [15:0]           walked;
		logic                  length_error;
		logic                  walk_done;
	} view_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] section_count;
		logic [31:0] total_length;
		logic [15:0] maker_code;
		logic [15:0] model_code;
		logic [15:0] revision_code;
	} result_t;

	function automatic logic [31:0] put_lane(logic [31:0] word, logic [1:0] lane,
		logic [7:0] b);
		logic [31:0] w;
		w = word;
		w[lane*8 +: 8] = b;
		return w;
	endfunction

endpackage

// ===== rtl/tcv_parse.sv =====
// Running parse state: header capture and section walk, one word per step.
module tcv_parse (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  tcv_pkg::item_t item,
	output tcv_pkg::view_t view
);

	logic [31:0] pos_q;
	logic [31:0] magic_q;
	logic [15:0] version_q;
	logic [15:0] declared_q;
	logic [tcv_pkg::FP_WORDS-1:0][15:0] fp_q;
	logic [31:0] total_q;
	logic [32:0] nss_q;
	logic [7:0]  len_lo_q;
	logic [15:0] walked_q;
	logic        lerr_q;

	logic [32:0] nss_n;
	logic [7:0]  len_lo_n;
	logic        take;
	logic        in_hdr;
	logic        sec_act;
	logic        is_lo;
	logic        is_hi;
	logic [15:0] sec_len;
	logic [32:0] room;
	logic        sec_fits;
	logic        sec_done;
	logic [3:0]  fp_off;
	logic [1:0]  fp_k;
	logic [1:0]  total_lane;
	logic [31:0] fp_tmp;

	assign take    = step && item.has_byte;
	assign in_hdr  = pos_q < 32'(tcv_pkg::HDR_BYTES);
	assign sec_act = take && !in_hdr && !lerr_q && (pos_q < total_q);
	assign is_lo   = {1'b0, pos_q} == nss_q + 33'd2;
	assign is_hi   = {1'b0, pos_q} == nss_q + 33'd3;
	assign sec_len = {item.data_byte, len_lo_q};
	assign room    = {1'b0, total_q} - nss_q - 33'(tcv_pkg::SEC_HDR_BYTES);
	assign sec_fits = !(room < {17'd0, sec_len});
	assign sec_done = sec_act && is_hi && sec_fits;
	assign fp_off  = pos_q[3:0] - 4'(tcv_pkg::POS_VENDOR);
	assign fp_k    = fp_off[2:1];
	assign total_lane = pos_q[1:0] - 2'(tcv_pkg::POS_TOTAL);

	always_comb begin
		view.pos      = pos_q;
		view.magic    = magic_q;
		view.version  = version_q;
		view.declared = declared_q;
		view.fp       = fp_q;
		view.total    = total_q;
		view.walked   = walked_q;
		view.length_error = lerr_q;
		nss_n    = nss_q;
		len_lo_n = len_lo_q;
		fp_tmp   = 32'd0;
		if (take) begin
			if (pos_q != 32'hFFFF_FFFF) begin
				view.pos = pos_q + 32'd1;
			end
			if (in_hdr) begin
				if (pos_q < 32'(tcv_pkg::POS_VERSION)) begin
					view.magic = tcv_pkg::put_lane(magic_q, pos_q[1:0], item.data_byte);
				end else if (pos_q < 32'(tcv_pkg::POS_DECLARED)) begin
					view.version[pos_q[0]*8 +: 8] = item.data_byte;
				end else if (pos_q < 32'(tcv_pkg::POS_VENDOR)) begin
					view.declared[pos_q[0]*8 +: 8] = item.data_byte;
				end else if (pos_q < 32'(tcv_pkg::POS_TOTAL)) begin
					fp_tmp = tcv_pkg::put_lane({16'd0, fp_q[fp_k]}, {1'b0, fp_off[0]},
						item.data_byte);
					view.fp[fp_k] = fp_tmp[15:0];
				end else begin
					view.total = tcv_pkg::put_lane(total_q, total_lane, item.data_byte);
				end
			end else if (sec_act) begin
				if (is_lo) begin
					len_lo_n = item.data_byte;
				end else if (is_hi) begin
					if (sec_fits) begin
						nss_n = nss_q + 33'(tcv_pkg::SEC_HDR_BYTES) + {17'd0, sec_len};
						view.walked = walked_q + 16'd1;
					end else begin
						view.length_error = 1'b1;
					end
				end
			end
		end
		// A section that ends here closes the walk exactly when it fills the room left.
		if (sec_done) begin
			view.walk_done = room == {17'd0, sec_len};
		end else begin
			view.walk_done = !(nss_q < {1'b0, view.total});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			magic_q    <= '0;
			version_q  <= '0;
			declared_q <= '0;
			fp_q       <= '0;
			total_q    <= '0;
			nss_q      <= 33'(tcv_pkg::HDR_BYTES);
			len_lo_q   <= '0;
			walked_q   <= '0;
			lerr_q     <= 1'b0;
		end else if (step && item.last_byte) begin
			pos_q      <= '0;
			magic_q    <= '0;
			version_q  <= '0;
			declared_q <= '0;
			fp_q       <= '0;
			total_q    <= '0;
			nss_q      <= 33'(tcv_pkg::HDR_BYTES);
			len_lo_q   <= '0;
			walked_q   <= '0;
			lerr_q     <= 1'b0;
		end else if (take) begin
			pos_q      <= view.pos;
			magic_q    <= view.magic;
			version_q  <= view.version;
			declared_q <= view.declared;
			fp_q       <= view.fp;
			total_q    <= view.total;
			nss_q      <= nss_n;
			len_lo_q   <= len_lo_n;
			walked_q   <= view.walked;
			lerr_q     <= view.length_error;
		end
	end

endmodule

// ===== rtl/tcv_check.sv =====
// Final checks of a finished container and the result word they produce.
module tcv_check (
	input  tcv_pkg::view_t   view,
	input  logic [31:0]      expected_magic,
	input  logic [15:0]      expected_version,
	output tcv_pkg::result_t result
);

	logic [2:0] st;

	always_comb begin
		if (view.pos == 32'd0) begin
			st = tcv_pkg::ST_EMPTY;
		end else if (view.pos < 32'(tcv_pkg::HDR_BYTES)) begin
			st = tcv_pkg::ST_BAD_LENGTH;
		end else if (view.magic != expected_magic) begin
			st = tcv_pkg::ST_BAD_MAGIC;
		end else if (view.version != expected_version) begin
			st = tcv_pkg::ST_BAD_VERSION;
		end else if (view.total < 32'(tcv_pkg::HDR_BYTES) || view.total > view.pos) begin
			st = tcv_pkg::ST_BAD_LENGTH;
		end else if (view.length_error || !view.walk_done) begin
			st = tcv_pkg::ST_BAD_LENGTH;
		end else if (view.walked != view.declared) begin
			st = tcv_pkg::ST_BAD_LENGTH;
		end else begin
			st = tcv_pkg::ST_OK;
		end
		result = '0;
		result.status = st;
		if (st == tcv_pkg::ST_OK) begin
			result.section_count = view.walked;
			result.total_length  = view.total;
			result.maker_code    = view.fp[0];
			result.model_code    = view.fp[1];
			result.revision_code = view.fp[2];
		end
	end

endmodule

// ===== rtl/tlv_container_validator_unit.sv =====
// Top level of the container validator: input register, parse, checks, result register.
//
// The block validates a container that arrives one byte per input word on the
// in_valid/in_ready channel. has_byte low marks a word that carries no byte;
// last_byte high ends the container and yields exactly one result word on the
// out_valid/out_ready channel with status, section count, total length and the
// vendor, product and release fields (all zero unless status is ok).
// The expected magic and version are written through cfg_valid/cfg_ready with
// cfg_index 0 for the magic and 1 for the version; write them while idle.
// A word is registered at acceptance and processed from the input register, and
// the result of a closing word is registered when that word is processed. One
// word is accepted per cycle, limited only by the single result register: while
// a result waits on a stalled receiver, a further closing word holds in the input
// register and new words wait, but non-closing words keep flowing.
// Reset clears the parse state, the expected values and the valid flags of both
// channel stages; after each closing word the parse state returns to its reset
// value for the next container while the configuration is kept.
module tlv_container_validator_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	input  logic        has_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [15:0] section_count,
	output logic [31:0] total_length,
	output logic [15:0] maker_code,
	output logic [15:0] model_code,
	output logic [15:0] revision_code,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);

	logic             valid_s1;
	tcv_pkg::item_t   item_s1;
	logic             adv;
	logic             step;
	logic             in_fire;
	logic [31:0]      exp_magic_q;
	logic [15:0]      exp_version_q;
	logic             out_valid_q;
	tcv_pkg::result_t result_q;
	tcv_pkg::result_t result;
	tcv_pkg::view_t   view;

	assign adv      = !item_s1.last_byte || !out_valid_q || out_ready;
	assign step     = valid_s1 && adv;
	assign in_ready = !valid_s1 || adv;
	assign in_fire  = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1.data_byte <= data_byte;
			item_s1.has_byte  <= has_byte;
			item_s1.last_byte <= last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_magic_q   <= '0;
			exp_version_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				tcv_pkg::CFG_MAGIC: begin
					exp_magic_q <= cfg_data;
				end
				tcv_pkg::CFG_VERSION: begin
					exp_version_q <= cfg_data[15:0];
				end
				default: begin
				end
			endcase
		end
	end

	tcv_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.view   (view)
	);

	tcv_check u_check (
		.view             (view),
		.expected_magic   (exp_magic_q),
		.expected_version (exp_version_q),
		.result           (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && item_s1.last_byte) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && item_s1.last_byte) begin
			result_q <= result;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = result_q.status;
	assign section_count = result_q.section_count;
	assign total_length  = result_q.total_length;
	assign maker_code    = result_q.maker_code;
	assign model_code    = result_q.model_code;
	assign revision_code = result_q.revision_code;

endmodule
